// ----- sv/emrt_pkg.sv -----
// ----------------------------------------------------------------------------
// emrt_pkg: shared types and constants of the exact-match route table
// Request and result words, the internal command word, and the codes used
// by the front and back ends.
// ----------------------------------------------------------------------------
package emrt_pkg;

  // Request kinds
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_DEL = 2'd1,
    OP_UPD = 2'd2,
    OP_FWD = 2'd3
  } op_t;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // Interface codes
  localparam logic [1:0] IF_ETH   = 2'd0;
  localparam logic [1:0] IF_ATM   = 2'd1;
  localparam logic [1:0] IF_FR    = 2'd2;
  localparam logic [1:0] IF_OTHER = 2'd3;

  localparam int unsigned NUM_COUNTED = 3;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned IDX_OUT_W   = 7;
  localparam int unsigned ACT_OUT_W   = 8;

  // Search granularity: hit bits examined per scan cycle
  localparam int unsigned CHUNK_W    = 16;
  localparam int unsigned CHUNK_BITS = 4;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] dest_addr;
    logic [ADDR_W-1:0] new_addr;
    logic [1:0]        iface_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [IDX_OUT_W-1:0] entry_index;
    logic [1:0]           route_iface;
    logic [CNT_W-1:0]     ethernet_packets;
    logic [CNT_W-1:0]     atm_packets;
    logic [CNT_W-1:0]     fr_packets;
    logic [CNT_W-1:0]     miss_packets;
    logic [ACT_OUT_W-1:0] active_routes;
  } out_item_t;

  // Classified request as the back end sees it
  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] key;
    logic [ADDR_W-1:0] new_addr;
    logic [1:0]        iface;
  } cmd_t;

endpackage

// ----- sv/emrt_ram.sv -----
// ----------------------------------------------------------------------------
// emrt_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module emrt_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 128
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/emrt_front.sv -----
// ----------------------------------------------------------------------------
// emrt_front: request intake and classification
// Decodes each accepted request word into a command and holds it in a
// short queue until the back end takes it.
// ----------------------------------------------------------------------------
module emrt_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  emrt_pkg::in_item_t in_item,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output emrt_pkg::cmd_t     cmd
);

  localparam int unsigned PTR_W = $clog2(emrt_pkg::QUEUE_DEPTH);
  localparam int unsigned FILL_W = $clog2(emrt_pkg::QUEUE_DEPTH + 1);

  emrt_pkg::cmd_t    q_r [emrt_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  emrt_pkg::cmd_t    cls;
  logic              do_push, do_pop;

  always_comb begin
    case (in_item.req_type)
      emrt_pkg::OP_ADD: cls.op = emrt_pkg::OP_ADD;
      emrt_pkg::OP_DEL: cls.op = emrt_pkg::OP_DEL;
      emrt_pkg::OP_UPD: cls.op = emrt_pkg::OP_UPD;
      default:          cls.op = emrt_pkg::OP_FWD;
    endcase
    cls.key      = in_item.dest_addr;
    cls.new_addr = in_item.new_addr;
    cls.iface    = in_item.iface_code;
  end

  assign full      = (fill_r == FILL_W'(emrt_pkg::QUEUE_DEPTH));
  assign cmd_valid = (fill_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(emrt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(emrt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ----- sv/emrt_back.sv -----
// ----------------------------------------------------------------------------
// emrt_back: route table, search and execution
// Holds the table, finds key matches (free slots for add), scans the hit
// vector for the lowest slot, applies the request and registers the result.
// ----------------------------------------------------------------------------
module emrt_back #(
  parameter int unsigned TABLE_ENTRIES = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  emrt_pkg::cmd_t      cmd,
  output logic                empty,
  input  logic                pop,
  output emrt_pkg::out_item_t out_item
);

  localparam int unsigned IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned TOT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned NCHUNK = (TABLE_ENTRIES + emrt_pkg::CHUNK_W - 1) / emrt_pkg::CHUNK_W;
  localparam int unsigned CH_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int unsigned HIT_W  = NCHUNK * emrt_pkg::CHUNK_W;
  localparam int unsigned CW     = emrt_pkg::CHUNK_W;
  localparam int unsigned CB     = emrt_pkg::CHUNK_BITS;
  localparam int unsigned AW     = emrt_pkg::ADDR_W;
  localparam int unsigned KW     = emrt_pkg::CNT_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CMP  = 5'b00010,
    S_SCAN = 5'b00100,
    S_READ = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  emrt_pkg::cmd_t      cur_r;
  logic [HIT_W-1:0]    hit_r, hit_nxt;
  logic [CH_W-1:0]     chunk_r, chunk_nxt;
  logic                found_r, found_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;

  logic                valid_r [TABLE_ENTRIES];
  logic [AW-1:0]       addr_r  [TABLE_ENTRIES];
  logic [TOT_W-1:0]    total_r, total_nxt;
  logic [KW-1:0]       fwd_cnt_r [emrt_pkg::NUM_COUNTED];
  logic [KW-1:0]       fwd_cnt_nxt [emrt_pkg::NUM_COUNTED];
  logic [KW-1:0]       miss_r, miss_nxt;

  emrt_pkg::out_item_t out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [CW-1:0]       low_chunk;
  logic [CB-1:0]       low_pos;
  logic [IDX_W-1:0]    scan_idx;
  logic                fire;
  logic                set_valid, clr_valid, addr_we, ram_we, ram_re;
  logic [AW-1:0]       addr_wdata;
  logic [1:0]          ram_rdata;

  function automatic logic [KW-1:0] sat_inc(input logic [KW-1:0] v);
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction

  // Lowest set bit of one chunk
  function automatic logic [CB-1:0] low_one(input logic [CW-1:0] v);
    low_one = '0;
    for (int i = CW - 1; i >= 0; i--) begin
      if (v[i]) begin
        low_one = CB'(i);
      end
    end
  endfunction

  assign low_chunk = hit_r[CW-1:0];
  assign low_pos   = low_one(low_chunk);
  assign scan_idx  = IDX_W'({chunk_r, low_pos});
  assign cmd_ready = (state_r == S_IDLE);
  assign fire      = (state_r == S_DONE) && (!out_valid_r || pop);
  assign ram_re    = (state_r == S_SCAN) && (|low_chunk);

  // Interface codes live in RAM; read only for the slot that the scan picks
  emrt_ram #(
    .WIDTH (2),
    .DEPTH (TABLE_ENTRIES)
  ) u_iface_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (cur_r.iface),
    .re    (ram_re),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  // Sequencer: compare, scan, read, execute
  always_comb begin
    state_nxt = state_r;
    hit_nxt   = hit_r;
    chunk_nxt = chunk_r;
    found_nxt = found_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        hit_nxt = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (cur_r.op == emrt_pkg::OP_ADD) begin
            hit_nxt[i] = !valid_r[i];
          end else begin
            hit_nxt[i] = valid_r[i] && (addr_r[i] == cur_r.key);
          end
        end
        chunk_nxt = '0;
        found_nxt = 1'b0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (|low_chunk) begin
          found_nxt = 1'b1;
          idx_nxt   = scan_idx;
          state_nxt = S_READ;
        end else if (chunk_r == CH_W'(NCHUNK - 1)) begin
          state_nxt = S_DONE;
        end else begin
          chunk_nxt = chunk_r + 1'b1;
          hit_nxt   = hit_r >> CW;
        end
      end
      S_READ: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Execute the request and build the result word
  always_comb begin
    set_valid     = 1'b0;
    clr_valid     = 1'b0;
    addr_we       = 1'b0;
    ram_we        = 1'b0;
    addr_wdata    = cur_r.key;
    total_nxt     = total_r;
    miss_nxt      = miss_r;
    for (int c = 0; c < emrt_pkg::NUM_COUNTED; c++) begin
      fwd_cnt_nxt[c] = fwd_cnt_r[c];
    end
    out_nxt             = out_r;
    out_nxt.status      = emrt_pkg::ST_OK;
    out_nxt.entry_index = '0;
    out_nxt.route_iface = '0;

    if (fire) begin
      if (!found_r) begin
        if (cur_r.op == emrt_pkg::OP_ADD) begin
          out_nxt.status = emrt_pkg::ST_FULL;
        end else begin
          out_nxt.status = emrt_pkg::ST_NOT_FOUND;
          if (cur_r.op == emrt_pkg::OP_FWD) begin
            miss_nxt = sat_inc(miss_r);
          end
        end
      end else begin
        out_nxt.entry_index = emrt_pkg::IDX_OUT_W'(idx_r);
        case (cur_r.op)
          emrt_pkg::OP_ADD: begin
            set_valid           = 1'b1;
            addr_we             = 1'b1;
            ram_we              = 1'b1;
            total_nxt           = total_r + 1'b1;
            out_nxt.route_iface = cur_r.iface;
          end
          emrt_pkg::OP_DEL: begin
            clr_valid           = 1'b1;
            total_nxt           = total_r - 1'b1;
            out_nxt.route_iface = ram_rdata;
          end
          emrt_pkg::OP_UPD: begin
            addr_we             = 1'b1;
            addr_wdata          = cur_r.new_addr;
            ram_we              = 1'b1;
            out_nxt.route_iface = cur_r.iface;
          end
          default: begin
            out_nxt.route_iface = ram_rdata;
            for (int c = 0; c < emrt_pkg::NUM_COUNTED; c++) begin
              if (ram_rdata == 2'(c)) begin
                fwd_cnt_nxt[c] = sat_inc(fwd_cnt_r[c]);
              end
            end
          end
        endcase
      end
      out_nxt.ethernet_packets = fwd_cnt_nxt[emrt_pkg::IF_ETH];
      out_nxt.atm_packets      = fwd_cnt_nxt[emrt_pkg::IF_ATM];
      out_nxt.fr_packets       = fwd_cnt_nxt[emrt_pkg::IF_FR];
      out_nxt.miss_packets     = miss_nxt;
      out_nxt.active_routes    = emrt_pkg::ACT_OUT_W'(total_nxt);
    end else begin
      out_nxt = out_r;
    end

    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign empty    = !out_valid_r;
  assign out_item = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      miss_r      <= '0;
      for (int c = 0; c < emrt_pkg::NUM_COUNTED; c++) begin
        fwd_cnt_r[c] <= '0;
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      total_r     <= total_nxt;
      miss_r      <= miss_nxt;
      for (int c = 0; c < emrt_pkg::NUM_COUNTED; c++) begin
        fwd_cnt_r[c] <= fwd_cnt_nxt[c];
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (idx_r == IDX_W'(i)) begin
          if (set_valid) begin
            valid_r[i] <= 1'b1;
          end else if (clr_valid) begin
            valid_r[i] <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_r   <= hit_nxt;
    chunk_r <= chunk_nxt;
    found_r <= found_nxt;
    idx_r   <= idx_nxt;
    out_r   <= out_nxt;
    if (cmd_valid && cmd_ready) begin
      cur_r <= cmd;
    end
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (addr_we && (idx_r == IDX_W'(i))) begin
        addr_r[i] <= addr_wdata;
      end
    end
  end

endmodule

// ----- sv/exact_match_route_table_core.sv -----
// ----------------------------------------------------------------------------
// exact_match_route_table_core: exact-match route table with counters
// Queue-style request and result ports around a table of destination
// addresses, each mapped to an interface code.
// ----------------------------------------------------------------------------
// A request word (add, delete, update or forward) goes in through push/full
// and exactly one result word comes out through empty/pop, in order. Add
// takes the lowest free slot; delete, update and forward act on the lowest
// valid slot whose address matches. Forward bumps the saturating counter of
// the matched interface (none for "other") or the miss counter. Each result
// reports the counters and the number of active routes after the request.
// In the back end a request goes through one compare step over all
// entries, then the hit vector is scanned 16 slots per cycle, then on a hit
// one interface RAM read, then one execute step, which waits while an
// untaken result is held. Requests are worked one at a time; a two-word
// queue in front and a result register behind keep both ports moving. No
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module exact_match_route_table_core #(
  parameter int unsigned TABLE_ENTRIES = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  emrt_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output emrt_pkg::out_item_t out_item
);

  // Front-to-back command handshake
  logic           cmd_valid;
  logic           cmd_ready;
  emrt_pkg::cmd_t cmd;

  // Accept and decode request words, hold them until the back end is free
  emrt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // Search the table, apply the request and hold the result word
  emrt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule

// ----- sv/emrt_checker.sv -----
// ----------------------------------------------------------------------------
// emrt_checker: port-level checks of the route table
// Watches the top-level ports and flags result words that break the rules
// of the block.
// ----------------------------------------------------------------------------
module emrt_checker #(
  parameter int unsigned TABLE_ENTRIES = 128
) (
  input logic                clk,
  input logic                rst_n,
  input logic                empty,
  input logic                pop,
  input emrt_pkg::out_item_t out_item
);

  // Nothing waits on the result side after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result pending after reset");

  // A waiting result holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("waiting result changed or vanished");

  // A failed request reports neither slot nor interface
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_item.status != emrt_pkg::ST_OK)) |->
      (out_item.entry_index == '0 && out_item.route_iface == '0))
    else $error("failed request reports a slot");

  // Table full only when every slot is in use
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_item.status == emrt_pkg::ST_FULL)) |->
      (out_item.active_routes == emrt_pkg::ACT_OUT_W'(TABLE_ENTRIES)))
    else $error("table full reported with free slots");

  // Only the three defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_item.status == emrt_pkg::ST_OK ||
                out_item.status == emrt_pkg::ST_FULL ||
                out_item.status == emrt_pkg::ST_NOT_FOUND))
    else $error("undefined status code");

endmodule

bind exact_match_route_table_core emrt_checker #(
  .TABLE_ENTRIES (TABLE_ENTRIES)
) u_emrt_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);
